// ----- rtl/seven_tap_sharpen_axis_filter_core_macros.svh -----
// ----------------------------------------------------------------------------
// Sharpen filter core - assertion macros
// Immediate-cycle and next-cycle implication checks on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef SEVEN_TAP_SHARPEN_AXIS_FILTER_CORE_MACROS_SVH
`define SEVEN_TAP_SHARPEN_AXIS_FILTER_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define STSF_CHECK_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define STSF_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/stsf_pkg.sv -----
// ----------------------------------------------------------------------------
// stsf_pkg - shared types and constants
// Word formats, pipeline structs and register indexes of the sharpen core.
// ----------------------------------------------------------------------------
`default_nettype none

package stsf_pkg;

  localparam int CH_W      = 8;
  localparam int NUM_CH    = 4;
  localparam int PIX_W     = CH_W * NUM_CH;
  localparam int HIST_N    = 6;
  localparam int COORD_W   = 11;
  localparam int SUM_W     = 17;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AXIS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd2048;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd2048;

  typedef struct packed {
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
    logic [CH_W-1:0] in_alpha;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0]    out_red;
    logic [CH_W-1:0]    out_green;
    logic [CH_W-1:0]    out_blue;
    logic [CH_W-1:0]    out_alpha;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic               run_last;
  } out_word_t;

  // pixel packed as {alpha, blue, green, red}: channel c at [8c +: 8]
  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [HIST_N-1:0] lanes_t;

  typedef logic signed [SUM_W-1:0] sum_t;

  // per-item control handed from the front end to the emitter
  typedef struct packed {
    logic               vert;
    logic               flush;
    logic               emit_any;
    logic [1:0]         t_first;
    logic [2:0]         pos_clip;
    logic [2:0]         pos_mod;
    logic [COORD_W-1:0] pos_lo;
    logic [COORD_W-1:0] x_lo;
    logic [COORD_W-1:0] y_lo;
  } item_meta_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               run_last;
  } res_tag_t;

  typedef struct packed {
    sum_t [NUM_CH-1:0] sum;
    res_tag_t          tag;
  } sum_word_t;

endpackage

`default_nettype wire

// ----- rtl/stsf_line_mem.sv -----
// ----------------------------------------------------------------------------
// stsf_line_mem - history store
// Six pixel lanes per address, registered read, single-lane masked write.
// ----------------------------------------------------------------------------
`default_nettype none

module stsf_line_mem #(
  parameter int DEPTH  = 2049,
  parameter int ADDR_W = 12
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    addr,
  input  logic [2:0]           wr_lane,
  input  stsf_pkg::pix_t       wr_data,
  output stsf_pkg::lanes_t     rd_data
);
  import stsf_pkg::*;

  lanes_t mem_r [DEPTH];
  lanes_t rd_data_r;

  // read-first: a same-address read returns the contents before the write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[addr];
    end
    if (wr_en) begin
      mem_r[addr][wr_lane] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/stsf_emit.sv -----
// ----------------------------------------------------------------------------
// stsf_emit - window assembly and tap sums
// Builds the seven-tap window, steps through the flush positions and
// registers the signed tap sums of all four channels.
// ----------------------------------------------------------------------------
`default_nettype none

module stsf_emit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  stsf_pkg::pix_t         item_pix,
  input  stsf_pkg::lanes_t       item_lanes,
  input  stsf_pkg::item_meta_t   item_meta,
  output logic                   sum_valid,
  input  logic                   sum_ready,
  output stsf_pkg::sum_word_t    sum_data
);
  import stsf_pkg::*;

  localparam int W_OUTER = 1;
  localparam int W_MID   = 6;
  localparam int W_NEAR  = 35;
  localparam int W_CTR   = 204;
  localparam int NTAP    = 7;
  localparam int NEXT    = HIST_N + 4;

  pix_t [HIST_N:0]  win_nxt;
  pix_t [HIST_N:0]  s2_win_r;
  item_meta_t       s2_meta_r;
  logic             s2_valid_r;
  logic [1:0]       s2_t_r;
  logic             s3_valid_r;
  sum_word_t        s3_data_r;
  sum_word_t        s3_nxt;
  pix_t [NEXT-1:0]  ext;
  logic             s3_ready;
  logic             emit_go;
  logic             s2_done;
  logic [1:0]       t_last;
  logic [COORD_W-1:0] p_pos;

  function automatic sum_t tap_sum(input logic [NTAP-1:0][CH_W-1:0] a);
    logic [15:0] pos_part;
    logic [14:0] neg_part;
    pos_part = 16'(a[3]) * 16'(W_CTR) + (16'(a[1]) + 16'(a[5])) * 16'(W_MID);
    neg_part = (15'(a[2]) + 15'(a[4])) * 15'(W_NEAR)
             + (15'(a[0]) + 15'(a[6])) * 15'(W_OUTER);
    return $signed({1'b0, pos_part}) - $signed({2'b00, neg_part});
  endfunction

  // window: clamp to the first position, rotate lanes by position mod 6
  always_comb begin
    logic [3:0] slot;
    slot = '0;
    for (int i = 0; i < HIST_N; i++) begin
      slot = 4'(item_meta.pos_mod) + 4'(i);
      if (slot >= 4'(HIST_N)) begin
        slot = slot - 4'(HIST_N);
      end
      if (item_meta.pos_clip == '0) begin
        win_nxt[i] = item_pix;
      end else if (item_meta.pos_clip >= 3'(HIST_N - i)) begin
        win_nxt[i] = item_lanes[slot[2:0]];
      end else begin
        win_nxt[i] = item_lanes[0];
      end
    end
    win_nxt[HIST_N] = item_pix;
  end

  assign s3_ready   = !s3_valid_r || sum_ready;
  assign t_last     = s2_meta_r.flush ? 2'd3 : 2'd0;
  assign emit_go    = s2_valid_r && s2_meta_r.emit_any && s3_ready;
  assign s2_done    = s2_valid_r && (!s2_meta_r.emit_any || (s3_ready && s2_t_r == t_last));
  assign item_ready = !s2_valid_r || s2_done;

  // positions past the current one all read the current pixel
  always_comb begin
    for (int k = 0; k < NEXT; k++) begin
      ext[k] = s2_win_r[(k < HIST_N) ? k : HIST_N];
    end
  end

  assign p_pos = s2_meta_r.pos_lo + COORD_W'(s2_t_r) - COORD_W'(3);

  always_comb begin
    logic [NTAP-1:0][CH_W-1:0] taps;
    taps = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      for (int k = 0; k < NTAP; k++) begin
        taps[k] = ext[4'(s2_t_r) + 4'(k)][c*CH_W +: CH_W];
      end
      s3_nxt.sum[c] = tap_sum(taps);
    end
    s3_nxt.tag.col      = s2_meta_r.vert ? s2_meta_r.x_lo : p_pos;
    s3_nxt.tag.row      = s2_meta_r.vert ? p_pos : s2_meta_r.y_lo;
    s3_nxt.tag.run_last = (s2_t_r == t_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (item_ready) begin
        s2_valid_r <= item_valid;
      end
      if (s3_ready) begin
        s3_valid_r <= emit_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s2_win_r  <= win_nxt;
      s2_meta_r <= item_meta;
      s2_t_r    <= item_meta.t_first;
    end else if (emit_go) begin
      s2_t_r <= s2_t_r + 2'd1;
    end
    if (emit_go) begin
      s3_data_r <= s3_nxt;
    end
  end

  assign sum_valid = s3_valid_r;
  assign sum_data  = s3_data_r;

endmodule

`default_nettype wire

// ----- rtl/stsf_round.sv -----
// ----------------------------------------------------------------------------
// stsf_round - divide by 144, round half to even, saturate
// Quotient by reciprocal in one stage, remainder and rounding in the next.
// ----------------------------------------------------------------------------
`default_nettype none

module stsf_round (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  sum_valid,
  output logic                  sum_ready,
  input  stsf_pkg::sum_word_t   sum_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output stsf_pkg::out_word_t   out_data
);
  import stsf_pkg::*;

  localparam int          DIV      = 144;
  localparam logic [12:0] RECIP9   = 13'd7282;   // ceil(2^16 / 9)
  localparam logic [7:0]  HALF_DIV = 8'd72;
  localparam logic [9:0]  SAT_MAX  = 10'd255;

  logic                          s4_valid_r;
  logic [NUM_CH-1:0][8:0]        s4_q_r;
  logic [NUM_CH-1:0][15:0]       s4_s_r;
  logic [NUM_CH-1:0]             s4_zero_r;
  res_tag_t                      s4_tag_r;
  logic [NUM_CH-1:0][8:0]        q_nxt;
  logic [NUM_CH-1:0]             zero_nxt;
  logic [NUM_CH-1:0][CH_W-1:0]   val_nxt;
  logic                          out_valid_r;
  out_word_t                     out_data_r;
  logic                          out_ready;
  logic                          s4_ready;

  assign out_ready = !out_valid_r || !out_stall;
  assign s4_ready  = !s4_valid_r || out_ready;
  assign sum_ready = s4_ready;

  // s/144 = floor(floor(s/16) / 9)
  always_comb begin
    logic [24:0] prod;
    prod = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      zero_nxt[c] = sum_data.sum[c][SUM_W-1] || (sum_data.sum[c] == '0);
      prod        = 25'(sum_data.sum[c][15:4]) * 25'(RECIP9);
      q_nxt[c]    = prod[24:16];
    end
  end

  always_comb begin
    logic [15:0] rem;
    logic        up;
    logic [9:0]  qr;
    rem = '0;
    up  = 1'b0;
    qr  = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      rem = s4_s_r[c] - 16'(s4_q_r[c]) * 16'(DIV);
      up  = (rem[7:0] > HALF_DIV) || (rem[7:0] == HALF_DIV && s4_q_r[c][0]);
      qr  = 10'(s4_q_r[c]) + 10'(up);
      if (s4_zero_r[c]) begin
        val_nxt[c] = '0;
      end else if (qr > SAT_MAX) begin
        val_nxt[c] = SAT_MAX[CH_W-1:0];
      end else begin
        val_nxt[c] = qr[CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s4_ready) begin
        s4_valid_r <= sum_valid;
      end
      if (out_ready) begin
        out_valid_r <= s4_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && sum_valid) begin
      s4_q_r    <= q_nxt;
      s4_zero_r <= zero_nxt;
      s4_tag_r  <= sum_data.tag;
      for (int c = 0; c < NUM_CH; c++) begin
        s4_s_r[c] <= sum_data.sum[c][15:0];
      end
    end
    if (out_ready && s4_valid_r) begin
      out_data_r.out_red   <= val_nxt[0];
      out_data_r.out_green <= val_nxt[1];
      out_data_r.out_blue  <= val_nxt[2];
      out_data_r.out_alpha <= val_nxt[3];
      out_data_r.out_col   <= s4_tag_r.col;
      out_data_r.out_row   <= s4_tag_r.row;
      out_data_r.run_last  <= s4_tag_r.run_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/seven_tap_sharpen_axis_filter_core.sv -----
// ----------------------------------------------------------------------------
// seven_tap_sharpen_axis_filter_core - 7-tap sharpening filter, one axis
// Filters a raster RGBA stream along rows or columns with taps
// -1 6 -35 204 -35 6 -1 / 144, edge clamped, round half even, saturated.
//
//   port group | dir | handshake          | word
//   in_*       | in  | in_valid/in_stall  | in_word_t  (one pixel)
//   out_*      | out | out_valid/out_stall| out_word_t (pixel + col/row tag)
//   cfg_*      | in  | cfg_we             | 12-bit data, register index
//
// Throughput one word per cycle unless a flush or out_stall holds the pipe; a
// word passes the front, window, tap-sum, quotient and output registers. A
// word that closes a row (horizontal) or a column (vertical) holds the window
// stage for one step per flushed result, up to four; in_stall rises meanwhile.
// Reset clears counters and stage valids and reloads config defaults, not the
// history store. Stalls ripple from out_stall through each stage to in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_tap_sharpen_axis_filter_core #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  stsf_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output stsf_pkg::out_word_t               out_data,
  input  logic                              cfg_we,
  input  logic [stsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stsf_pkg::CFG_W-1:0]        cfg_wdata
);
  import stsf_pkg::*;

  `include "seven_tap_sharpen_axis_filter_core_macros.svh"

  // counter widths follow the image maxima
  localparam int XW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int SZ_W     = ($clog2(MAX_DIM + 1) > CFG_W) ? $clog2(MAX_DIM + 1) : CFG_W;
  // one address per column for the six line stores, plus one for the row history
  localparam int MEM_DEPTH = MAX_WIDTH + 1;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  // configuration
  logic                 axis_r;
  logic [CFG_W-1:0]     width_r;
  logic [CFG_W-1:0]     height_r;

  // raster position and its value mod 6
  logic [XW-1:0]        x_r, x_nxt;
  logic [YW-1:0]        y_r, y_nxt;
  logic [2:0]           xm6_r, xm6_nxt;
  logic [2:0]           ym6_r, ym6_nxt;

  logic [SZ_W-1:0]      width_s, height_s, eff_w, eff_h;
  logic [SZ_W-1:0]      x_s, y_s, pos_s;
  logic                 col_last, row_last, last;
  logic                 in_fire;
  pix_t                 cur_pix;
  item_meta_t           meta_nxt;

  // front stage: item registered alongside the store read
  logic                 s1_valid_r;
  pix_t                 s1_pix_r;
  item_meta_t           s1_meta_r;
  logic                 s1_ready;
  logic                 s2_ready;

  logic [MEM_AW-1:0]    mem_addr;
  lanes_t               mem_rdata;

  sum_word_t            sum_data;
  logic                 sum_valid;
  logic                 sum_ready;

  // effective sizes: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    width_s  = SZ_W'(width_r);
    height_s = SZ_W'(height_r);
    if (width_r == '0) begin
      eff_w = SZ_W'(1);
    end else if (width_s > SZ_W'(MAX_WIDTH)) begin
      eff_w = SZ_W'(MAX_WIDTH);
    end else begin
      eff_w = width_s;
    end
    if (height_r == '0) begin
      eff_h = SZ_W'(1);
    end else if (height_s > SZ_W'(MAX_HEIGHT)) begin
      eff_h = SZ_W'(MAX_HEIGHT);
    end else begin
      eff_h = height_s;
    end
  end

  assign x_s      = SZ_W'(x_r);
  assign y_s      = SZ_W'(y_r);
  // at or past the last position counts as last (covers a shrunken size)
  assign col_last = x_s >= eff_w - SZ_W'(1);
  assign row_last = y_s >= eff_h - SZ_W'(1);
  assign last     = axis_r ? row_last : col_last;
  assign pos_s    = axis_r ? y_s : x_s;

  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;
  assign in_fire  = in_valid && !in_stall;

  assign cur_pix = {in_data.in_alpha, in_data.in_blue, in_data.in_green, in_data.in_red};

  // per-item control: which flush steps produce a result
  always_comb begin
    meta_nxt.vert     = axis_r;
    meta_nxt.flush    = last;
    meta_nxt.emit_any = last || (pos_s >= SZ_W'(3));
    meta_nxt.t_first  = (pos_s >= SZ_W'(3)) ? 2'd0 : 2'd3 - pos_s[1:0];
    meta_nxt.pos_clip = (pos_s >= SZ_W'(HIST_N)) ? 3'(HIST_N) : pos_s[2:0];
    meta_nxt.pos_mod  = axis_r ? ym6_r : xm6_r;
    meta_nxt.pos_lo   = pos_s[COORD_W-1:0];
    meta_nxt.x_lo     = x_s[COORD_W-1:0];
    meta_nxt.y_lo     = y_s[COORD_W-1:0];
  end

  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    xm6_nxt = xm6_r;
    ym6_nxt = ym6_r;
    if (in_fire) begin
      if (col_last) begin
        x_nxt   = '0;
        xm6_nxt = '0;
        if (row_last) begin
          y_nxt   = '0;
          ym6_nxt = '0;
        end else begin
          y_nxt   = y_r + YW'(1);
          ym6_nxt = (ym6_r == 3'(HIST_N - 1)) ? 3'd0 : ym6_r + 3'd1;
        end
      end else begin
        x_nxt   = x_r + XW'(1);
        xm6_nxt = (xm6_r == 3'(HIST_N - 1)) ? 3'd0 : xm6_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r     <= 1'b0;
      width_r    <= WIDTH_RST;
      height_r   <= HEIGHT_RST;
      x_r        <= '0;
      y_r        <= '0;
      xm6_r      <= '0;
      ym6_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_AXIS:   axis_r   <= cfg_wdata[0];
          REG_WIDTH:  width_r  <= cfg_wdata;
          REG_HEIGHT: height_r <= cfg_wdata;
          default:    ;
        endcase
      end
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      xm6_r <= xm6_nxt;
      ym6_r <= ym6_nxt;
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r  <= cur_pix;
      s1_meta_r <= meta_nxt;
    end
  end

  // vertical: column x holds the six line entries; horizontal: the fixed
  // top address holds the six-pixel row history. Read and lane write share
  // the accept edge, so the read sees the word before this pixel lands.
  assign mem_addr = axis_r ? MEM_AW'(x_r) : MEM_AW'(MAX_WIDTH);

  stsf_line_mem #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (MEM_AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .wr_en   (in_fire),
    .addr    (mem_addr),
    .wr_lane (meta_nxt.pos_mod),
    .wr_data (cur_pix),
    .rd_data (mem_rdata)
  );

  stsf_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item_ready (s2_ready),
    .item_pix   (s1_pix_r),
    .item_lanes (mem_rdata),
    .item_meta  (s1_meta_r),
    .sum_valid  (sum_valid),
    .sum_ready  (sum_ready),
    .sum_data   (sum_data)
  );

  stsf_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_data  (sum_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // checks
  `STSF_CHECK_NEXT(a_accept_loads_s1, in_fire, s1_valid_r,
                   "accepted word lost at front stage")
  `STSF_CHECK_NEXT(a_s1_holds, s1_valid_r && !s2_ready,
                   s1_valid_r && $stable(s1_meta_r) && $stable(mem_rdata),
                   "front stage or store read changed while held")
  `STSF_CHECK_NOW(a_mod6_range, 1'b1,
                  (xm6_r < 3'(HIST_N)) && (ym6_r < 3'(HIST_N)),
                  "position mod 6 out of range")

endmodule

`default_nettype wire

// ----- tb/sv/seven_tap_sharpen_axis_filter_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_tap_sharpen_axis_filter_core_tb - self-checking bench for the sharpen core
// Streams RGBA words through the core in both axis modes. A class-based
// predictor mirrors counters, row history and line stores, computes every
// filtered word, and checks each output word in order, field by field.
// ----------------------------------------------------------------------------

module seven_tap_sharpen_axis_filter_core_tb;

  import stsf_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 16;      // settle time after the queue empties
  localparam int unsigned DRAIN_CAP     = 20000;   // bound on any drain wait

  // --------------------------------------------------------------------------
  // Predictor: own copy of config, raster counters and history stores.
  // Each input word queues zero to four filtered words in output order.
  // --------------------------------------------------------------------------
  class filtered_pixel_board;
    localparam int unsigned LINE_W = 2048;

    logic        axis_vert;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    int unsigned col_cnt;
    int unsigned row_cnt;
    pix_t        row_hist [HIST_N];
    pix_t        line_mem [HIST_N * LINE_W];
    out_word_t   filtered_due [$];
    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned pixels_taken;

    function new();
      axis_vert     = 1'b0;
      width_reg     = WIDTH_RST;
      height_reg    = HEIGHT_RST;
      col_cnt       = 0;
      row_cnt       = 0;
      mismatches    = 0;
      words_checked = 0;
      pixels_taken  = 0;
      foreach (row_hist[i]) row_hist[i] = '0;
      foreach (line_mem[i]) line_mem[i] = '0;
    endfunction

    // 0 acts as 1, anything past the store size acts as the store size
    function int unsigned usable_size(logic [11:0] v);
      if (v == 0) return 1;
      if (v > LINE_W) return LINE_W;
      return int'(v);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_AXIS:   axis_vert  = val[0];
        REG_WIDTH:  width_reg  = val;
        REG_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    // one channel over seven taps starting at win[first]
    function logic [7:0] sharpen_byte(pix_t win [10], int unsigned first,
                                      int unsigned lane);
      int taps [7] = '{-1, 6, -35, 204, -35, 6, -1};
      int acc;
      int q;
      int r;
      acc = 0;
      for (int k = 0; k < 7; k++)
        acc += taps[k] * int'(win[first + k][CH_W*lane +: CH_W]);
      if (acc <= 0) return 8'd0;
      q = acc / 144;
      r = acc % 144;
      // round half to even
      if (r > 72 || (r == 72 && q[0])) q++;
      if (q > 255) q = 255;
      return q[7:0];
    endfunction

    function void take_pixel(in_word_t px);
      int unsigned w, h, x, y, pos, need, idx, t, tmax;
      bit          vert, col_end, row_end, at_end;
      pix_t        cur;
      pix_t        win [10];
      out_word_t   res;
      w       = usable_size(width_reg);
      h       = usable_size(height_reg);
      x       = col_cnt;
      y       = row_cnt;
      col_end = x >= w - 1;
      row_end = y >= h - 1;
      vert    = axis_vert;
      pos     = vert ? y : x;
      at_end  = vert ? row_end : col_end;
      cur     = {px.in_alpha, px.in_blue, px.in_green, px.in_red};
      pixels_taken++;

      // six taps behind, clamped to the first position on the axis
      for (int i = 0; i < 6; i++) begin
        need = 6 - i;
        idx  = (pos >= need) ? pos - need : 0;
        if (idx == pos)
          win[i] = cur;
        else if (vert)
          win[i] = line_mem[(idx % HIST_N) * LINE_W + x];
        else
          win[i] = row_hist[idx % HIST_N];
      end
      // taps past the far edge repeat the current pixel
      for (int i = 6; i < 10; i++) win[i] = cur;

      if (vert) line_mem[(pos % HIST_N) * LINE_W + x] = cur;
      else      row_hist[pos % HIST_N] = cur;

      tmax = at_end ? 3 : 0;
      for (t = 0; t <= tmax; t++) begin
        if (pos + t < 3) continue;
        res.out_red   = sharpen_byte(win, t, 0);
        res.out_green = sharpen_byte(win, t, 1);
        res.out_blue  = sharpen_byte(win, t, 2);
        res.out_alpha = sharpen_byte(win, t, 3);
        res.out_col   = vert ? x[COORD_W-1:0] : COORD_W'(pos + t - 3);
        res.out_row   = vert ? COORD_W'(pos + t - 3) : y[COORD_W-1:0];
        // if any position emits, the final one does
        res.run_last  = (t == tmax);
        filtered_due.push_back(res);
      end

      if (col_end) begin
        col_cnt = 0;
        row_cnt = row_end ? 0 : y + 1;
      end else begin
        col_cnt = x + 1;
      end
    endfunction

    function void field_check(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_filtered(out_word_t got);
      out_word_t want;
      if (filtered_due.size() == 0) begin
        $error("output word with none expected: col %0d row %0d",
               got.out_col, got.out_row);
        mismatches++;
        return;
      end
      want = filtered_due.pop_front();
      words_checked++;
      field_check("out_red",   want.out_red,   got.out_red);
      field_check("out_green", want.out_green, got.out_green);
      field_check("out_blue",  want.out_blue,  got.out_blue);
      field_check("out_alpha", want.out_alpha, got.out_alpha);
      field_check("out_col",   want.out_col,   got.out_col);
      field_check("out_row",   want.out_row,   got.out_row);
      field_check("run_last",  want.run_last,  got.run_last);
    endfunction

    function int unsigned outstanding();
      return filtered_due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_word_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  filtered_pixel_board board;
  int unsigned         burst_left = 0;
  int unsigned         frames_run = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  seven_tap_sharpen_axis_filter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Stimulus helpers. Every task is entered and left right after a rising
  // edge, so each signal sees at most one nonblocking update per time step.
  // --------------------------------------------------------------------------
  function automatic in_word_t pixel(logic [7:0] r, logic [7:0] g,
                                     logic [7:0] b, logic [7:0] a);
    in_word_t px;
    px.in_red   = r;
    px.in_green = g;
    px.in_blue  = b;
    px.in_alpha = a;
    return px;
  endfunction

  // bias toward rails so saturation and clipping to zero show up often
  function automatic logic [7:0] random_byte();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) return 8'h00;
    if (pick < 24) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic in_word_t random_pixel();
    return pixel(random_byte(), random_byte(), random_byte(), random_byte());
  endfunction

  // mostly back-to-back, some short gaps, a few long ones, and bursts
  // with no gaps at all
  function automatic int unsigned sender_gap();
    int unsigned pick;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  task automatic send_pixel(in_word_t px);
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    board.take_pixel(px);
  endtask

  // hold off the sender until every queued word is out, then let the pipe
  // empty of words that produce nothing
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (board.outstanding() != 0 && waited < DRAIN_CAP) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, val);
    @(posedge clk);
  endtask

  // one full image under a fresh setting; counters start and end at zero
  task automatic run_frame(logic vert, logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    int unsigned count;
    wait_drained();
    write_reg(REG_AXIS, CFG_W'(vert));
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    count = board.usable_size(w) * board.usable_size(h);
    repeat (count) send_pixel(random_pixel());
    frames_run++;
  endtask

  // rows counted against the largest height, then the height drops below
  // the row counter so the next row closes the image
  task automatic tall_then_cut_frame(logic [CFG_W-1:0] w);
    wait_drained();
    write_reg(REG_AXIS, CFG_W'(1'b0));
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, 12'd4095);
    repeat (2 * board.usable_size(w)) send_pixel(random_pixel());
    wait_drained();
    write_reg(REG_HEIGHT, 12'd1);
    repeat (board.usable_size(w)) send_pixel(random_pixel());
    frames_run++;
  endtask

  // --------------------------------------------------------------------------
  // Output side: check every accepted word, stall in random patterns
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.match_filtered(out_data);
  end

  initial begin : sink_pacing
    int unsigned pick;
    int unsigned span;
    @(posedge clk);
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        out_stall <= 1'b0;               // long free-flowing stretch
        span = $urandom_range(10, 60);
      end else if (pick < 60) begin
        out_stall <= 1'b0;
        span = $urandom_range(1, 4);
      end else if (pick < 92) begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;               // long back-pressure
        span = $urandom_range(8, 20);
      end
      repeat (span) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned rand_start;
    int unsigned pick;
    logic [CFG_W-1:0] w, h;
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting (rows, 2048 x 2048): part of a row, rail values.
    send_pixel(pixel(8'hFF, 8'h00, 8'hFF, 8'h00));
    send_pixel(pixel(8'h00, 8'hFF, 8'h00, 8'hFF));
    send_pixel(pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(pixel(8'h00, 8'h00, 8'h00, 8'h00));
    send_pixel(pixel(8'h80, 8'h7F, 8'h01, 8'hFE));

    // Width shrinks under the column counter: the next word closes the row
    // and flushes four positions.
    wait_drained();
    write_reg(REG_WIDTH, 12'd3);
    send_pixel(pixel(8'h55, 8'hAA, 8'h0F, 8'hF0));

    // Row counter sits past the new height; 7-wide row built so position 3
    // rounds a half up to even (red), a half down to even (green),
    // saturates high (blue) and clips a negative sum (alpha).
    wait_drained();
    write_reg(REG_HEIGHT, 12'd1);
    write_reg(REG_WIDTH, 12'd7);
    send_pixel(pixel(8'd0,  8'd0,  8'd0,   8'd255));
    send_pixel(pixel(8'd0,  8'd0,  8'd0,   8'd255));
    send_pixel(pixel(8'd0,  8'd0,  8'd0,   8'd255));
    send_pixel(pixel(8'd0,  8'd0,  8'd255, 8'd0));
    send_pixel(pixel(8'd0,  8'd0,  8'd0,   8'd255));
    send_pixel(pixel(8'd36, 8'd12, 8'd0,   8'd255));
    send_pixel(pixel(8'd0,  8'd0,  8'd0,   8'd255));

    // Short axis: two-pixel row flushes only positions 0 and 1.
    wait_drained();
    write_reg(REG_WIDTH, 12'd2);
    send_pixel(random_pixel());
    send_pixel(random_pixel());

    // Width 0 acts as one pixel per row.
    wait_drained();
    write_reg(REG_WIDTH, 12'd0);
    write_reg(REG_HEIGHT, 12'd2);
    send_pixel(random_pixel());
    send_pixel(random_pixel());

    // Column mode, small 3 x 3 image.
    run_frame(1'b1, 12'd3, 12'd3);

    // Random images, mostly small, both axes, with zero sizes mixed in.
    rand_start = board.pixels_taken;
    while (board.pixels_taken - rand_start < 70) begin
      if (frames_run == 3) begin
        tall_then_cut_frame(CFG_W'($urandom_range(2, 5)));
      end else begin
        pick = $urandom_range(0, 99);
        w = (pick < 10) ? 12'd0 : CFG_W'($urandom_range(1, 8));
        pick = $urandom_range(0, 99);
        h = (pick < 10) ? 12'd0 : CFG_W'($urandom_range(1, 6));
        run_frame(1'($urandom_range(0, 1)), w, h);
      end
    end

    wait_drained();
    if (board.outstanding() != 0) begin
      $error("%0d filtered words never arrived", board.outstanding());
      board.mismatches += board.outstanding();
    end

    $display("Covered %0d pixels over %0d images, row and column modes,",
             board.pixels_taken, frames_run);
    $display("sizes from zero up to 4095; %0d output words checked, %0d errors.",
             board.words_checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("PASS seven_tap_sharpen_axis_filter_core");
    end else begin
      $display("FAIL seven_tap_sharpen_axis_filter_core");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("FAIL seven_tap_sharpen_axis_filter_core");
    $finish;
  end

endmodule
